// File: sv/dsl_pkg.sv
`default_nettype none

package dsl_pkg;

  // command codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_WEIGHT  = 3'd0,
    CMD_INPUT   = 3'd1,
    CMD_FORWARD = 3'd2,
    CMD_TARGET  = 3'd3,
    CMD_DELTA   = 3'd4,
    CMD_TRAIN   = 3'd5
  } cmd_t;

  // result kinds
  localparam logic KIND_ACT   = 1'b0;
  localparam logic KIND_DELTA = 1'b1;

  // register indexes
  localparam logic REG_RATE = 1'b0;

  localparam logic [15:0] RATE_RESET = 16'd6554;

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_RD, S_F_MUL, S_F_ACC, S_F_SAT, S_F_OUT,
    S_T_RD, S_T_M1, S_T_M2, S_T_WR,
    S_U_RD, S_U_M1, S_U_M2, S_U_WB,
    S_B_RD, S_B_MUL, S_B_ACC, S_B_SAT, S_B_M1, S_B_M2, S_B_OUT
  } state_t;

  // round half up: floor((v + 2^(n-1)) / 2^n)
  function automatic logic signed [55:0] rnd_shift(input logic signed [55:0] v,
                                                    input int unsigned n);
    logic signed [55:0] t;
    t = v + (56'sd1 <<< (n - 1));
    return t >>> n;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
    logic signed [15:0] r;
    if (v > 56'sd32767) r = 16'sh7fff;
    else if (v < -56'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // shift-subtract division, used only while building the sigmoid table
  function automatic longint unsigned ldiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // exp(-x), x in Q12, result in Q30
  function automatic longint unsigned exp_neg(input longint unsigned x);
    longint unsigned one;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned u4;
    longint unsigned p;
    one = 64'd1 << 30;
    u   = x << 8;
    u2  = (u * u) >> 30;
    u3  = (u2 * u) >> 30;
    u4  = (u3 * u) >> 30;
    p   = one - u + u2 / 2 - u3 / 6 + u4 / 24;
    for (int k = 0; k < 10; k++) p = (p * p + (64'd1 << 29)) >> 30;
    return p;
  endfunction

  // sigmoid of gain 2 at the center of bin k
  function automatic logic [15:0] sig_entry(input int k, input int depth);
    longint v;
    longint unsigned a;
    longint unsigned den;
    longint unsigned r;
    longint res;
    v   = -65536 + longint'(ldiv(longint'(2 * k + 1) * 65536, longint'(depth)));
    a   = (v < 0) ? -v : v;
    den = (64'd1 << 30) + exp_neg(a);
    r   = ldiv((64'd1 << 42) + (den >> 1), den);
    res = (v < 0) ? 4096 - longint'(r) : longint'(r);
    return res[15:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/dsl_op_if.sv
`default_nettype none

interface dsl_op_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [5:0]        row;
  logic [5:0]        col;
  logic signed [15:0] value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

`default_nettype wire

// File: sv/dsl_res_if.sv
`default_nettype none

interface dsl_res_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         index;
  logic signed [15:0] result_value;
  logic               last;

  modport source (output valid, kind, index, result_value, last, input ready);
  modport sink   (input valid, kind, index, result_value, last, output ready);
endinterface

`default_nettype wire

// File: sv/dense_sigmoid_layer_trainer.sv
`default_nettype none

// channel  | dir | handshake   | payload
// op       | in  | valid/ready | cmd, row, col, value
// res      | out | valid/ready | kind, index, result_value, last
// apb      | in  | psel/penable| learning_rate at byte address 0
//
// sequencing: weight, input and delta writes complete in the idle state; target,
//   forward and train step through state sequences that share the single
//   multiplier, one product at a time
// reset: rst is synchronous; clears the sequencer, the output slot, the
//   learning rate and the valid bits of the activation and delta stores
// stalls: a result waits in the output register; the sequencer holds at the
//   emit step while that register is full, op.ready is high only when idle

module dense_sigmoid_layer_trainer
  import dsl_pkg::*;
#(
  parameter int NUM_IN              = 16,
  parameter int NUM_OUT             = 16,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  dsl_op_if.sink      op,
  dsl_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = NUM_OUT * NUM_IN;
  localparam int WA = (NW > 1) ? $clog2(NW) : 1;
  localparam int IA = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
  localparam int OA = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;
  localparam int TA = $clog2(SIGMOID_TABLE_DEPTH);

  // sigmoid table, built at elaboration
  logic [15:0] sig_rom [SIGMOID_TABLE_DEPTH];
  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_rom
    assign sig_rom[g] = sig_entry(g, SIGMOID_TABLE_DEPTH);
  end

  // config register
  logic [15:0] lr;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RATE) ? {16'd0, lr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lr <= RATE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_RATE) begin
      lr <= pwdata[15:0];
    end
  end

  // sequencer state and loop counters
  state_t state, state_next;
  logic [OA-1:0] i;
  logic [IA-1:0] j;
  logic i_last, j_last;
  assign i_last = (i == OA'(NUM_OUT - 1));
  assign j_last = (j == IA'(NUM_IN - 1));

  logic accept;
  assign op.ready = (state == S_IDLE);
  assign accept   = op.valid && op.ready;

  logic row_ok, col_ok;
  assign row_ok = ({1'b0, op.row} < 7'(NUM_OUT));
  assign col_ok = ({1'b0, op.col} < 7'(NUM_IN));

  // stores
  logic signed [15:0] wmem [NW];
  logic signed [15:0] xmem [NUM_IN];
  logic signed [15:0] ymem [NUM_OUT];
  logic signed [15:0] dmem [NUM_OUT];
  logic [NUM_OUT-1:0] yvalid, dvalid;
  logic signed [15:0] wq, xq, yq, dq;

  logic [12:0] w_rfull, w_afull;
  logic [WA-1:0] w_raddr;
  assign w_rfull = 13'(i) * 13'(NUM_IN) + 13'(j);
  assign w_afull = 13'(op.row) * 13'(NUM_IN) + 13'(op.col);
  assign w_raddr = w_rfull[WA-1:0];

  // shared multiplier and accumulator
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic               mul_en;
  logic signed [51:0] mul_p;
  logic signed [39:0] acc;
  logic signed [15:0] sq;   // saturated sum
  logic signed [15:0] tq;   // target value

  // output slot
  logic              ov;
  logic              out_load;
  logic              out_free;
  logic              o_kind;
  logic [5:0]        o_index;
  logic signed [15:0] o_value;
  logic              o_last;
  assign out_free = !ov || res.ready;

  // write controls
  logic              w_we;
  logic [WA-1:0]     w_waddr;
  logic signed [15:0] w_wdata;
  logic              d_we;
  logic [OA-1:0]     d_waddr;
  logic signed [15:0] d_wdata;

  // sigmoid lookup
  logic [15:0] sig_u;
  logic [28:0] sig_prod;
  logic [TA-1:0] sig_idx;
  assign sig_u    = {~sq[15], sq[14:0]};
  assign sig_prod = 29'(sig_u) * 29'(SIGMOID_TABLE_DEPTH);
  assign sig_idx  = sig_prod[16 +: TA];

  logic signed [15:0] wb_value;
  logic signed [15:0] deriv_value;
  assign wb_value    = sat16(56'(wq) - rnd_shift(56'(mul_p), 28));
  assign deriv_value = sat16(rnd_shift(56'(mul_p), 24));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (op.cmd == CMD_FORWARD) state_next = S_F_RD;
          else if (op.cmd == CMD_TRAIN) state_next = S_U_RD;
          else if (op.cmd == CMD_TARGET && row_ok) state_next = S_T_RD;
          else state_next = S_IDLE;
        end
      end
      S_F_RD:  state_next = S_F_MUL;
      S_F_MUL: state_next = S_F_ACC;
      S_F_ACC: state_next = j_last ? S_F_SAT : S_F_RD;
      S_F_SAT: state_next = S_F_OUT;
      S_F_OUT: if (out_free) state_next = i_last ? S_IDLE : S_F_RD;
      S_T_RD:  state_next = S_T_M1;
      S_T_M1:  state_next = S_T_M2;
      S_T_M2:  state_next = S_T_WR;
      S_T_WR:  state_next = S_IDLE;
      S_U_RD:  state_next = S_U_M1;
      S_U_M1:  state_next = S_U_M2;
      S_U_M2:  state_next = S_U_WB;
      S_U_WB:  state_next = (i_last && j_last) ? S_B_RD : S_U_RD;
      S_B_RD:  state_next = S_B_MUL;
      S_B_MUL: state_next = S_B_ACC;
      S_B_ACC: state_next = i_last ? S_B_SAT : S_B_RD;
      S_B_SAT: state_next = S_B_M1;
      S_B_M1:  state_next = S_B_M2;
      S_B_M2:  state_next = S_B_OUT;
      S_B_OUT: if (out_free) state_next = j_last ? S_IDLE : S_B_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    out_load = 1'b0;
    w_we     = 1'b0;
    w_waddr  = w_afull[WA-1:0];
    w_wdata  = op.value;
    d_we     = 1'b0;
    d_waddr  = op.row[OA-1:0];
    d_wdata  = op.value;
    unique case (state)
      S_IDLE: begin
        w_we = accept && op.cmd == CMD_WEIGHT && row_ok && col_ok;
        d_we = accept && op.cmd == CMD_DELTA && row_ok;
      end
      S_F_MUL, S_B_MUL: begin
        mul_en = 1'b1;
        mul_a  = 34'(wq);
        mul_b  = 18'((state == S_F_MUL) ? xq : dq);
      end
      S_T_M1: begin
        mul_en = 1'b1;
        mul_a  = 34'(18'(yq) - 18'(tq));
        mul_b  = 18'(yq);
      end
      S_T_M2: begin
        mul_en = 1'b1;
        mul_a  = signed'(mul_p[33:0]);
        mul_b  = 18'sd4096 - 18'(yq);
      end
      S_T_WR: begin
        d_we    = 1'b1;
        d_waddr = i;
        d_wdata = deriv_value;
      end
      S_U_M1: begin
        mul_en = 1'b1;
        mul_a  = 34'(xq);
        mul_b  = 18'(dq);
      end
      S_U_M2: begin
        mul_en = 1'b1;
        mul_a  = signed'(mul_p[33:0]);
        mul_b  = signed'({2'b00, lr});
      end
      S_U_WB: begin
        w_we    = 1'b1;
        w_waddr = w_raddr;
        w_wdata = wb_value;
      end
      S_B_M1: begin
        mul_en = 1'b1;
        mul_a  = 34'(sq);
        mul_b  = 18'(xq);
      end
      S_B_M2: begin
        mul_en = 1'b1;
        mul_a  = signed'(mul_p[33:0]);
        mul_b  = 18'sd4096 - 18'(xq);
      end
      S_F_OUT, S_B_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    wq <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && op.cmd == CMD_INPUT && col_ok) xmem[op.col[IA-1:0]] <= op.value;
    xq <= xmem[j];
  end

  always_ff @(posedge clk) begin
    if (state == S_F_OUT && out_load) ymem[i] <= signed'(sig_rom[sig_idx]);
    yq <= yvalid[i] ? ymem[i] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    dq <= dvalid[i] ? dmem[i] : 16'sd0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ov     <= 1'b0;
      yvalid <= '0;
      dvalid <= '0;
    end else begin
      state <= state_next;
      if (out_load) ov <= 1'b1;
      else if (res.ready) ov <= 1'b0;
      if (state == S_F_OUT && out_load) yvalid[i] <= 1'b1;
      if (d_we) dvalid[d_waddr] <= 1'b1;
    end
  end

  // counters, accumulator and payload
  always_ff @(posedge clk) begin
    if (mul_en) mul_p <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        // passes start at neuron 0, a target works on its own row
        i   <= (op.cmd == CMD_FORWARD || op.cmd == CMD_TRAIN) ? '0 : op.row[OA-1:0];
        j   <= '0;
        acc <= '0;
        tq  <= op.value;
      end
      S_F_ACC: begin
        acc <= acc + 40'(mul_p);
        if (!j_last) j <= j + 1'b1;
      end
      S_B_ACC: begin
        acc <= acc + 40'(mul_p);
        if (!i_last) i <= i + 1'b1;
      end
      S_F_SAT, S_B_SAT: sq <= sat16(rnd_shift(56'(acc), 12));
      S_F_OUT: begin
        if (out_free) begin
          o_kind  <= KIND_ACT;
          o_index <= 6'(i);
          o_value <= signed'(sig_rom[sig_idx]);
          o_last  <= i_last;
          i       <= i + 1'b1;
          j       <= '0;
          acc     <= '0;
        end
      end
      S_U_WB: begin
        if (j_last) begin
          j <= '0;
          i <= i_last ? '0 : i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
        acc <= '0;
      end
      S_B_OUT: begin
        if (out_free) begin
          o_kind  <= KIND_DELTA;
          o_index <= 6'(j);
          o_value <= deriv_value;
          o_last  <= j_last;
          j       <= j + 1'b1;
          i       <= '0;
          acc     <= '0;
        end
      end
      default: ;
    endcase
  end

  assign res.valid        = ov;
  assign res.kind         = o_kind;
  assign res.index        = o_index;
  assign res.result_value = o_value;
  assign res.last         = o_last;

  // last flag marks the final neuron of the pass
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |->
      (res.kind == KIND_ACT && 32'(res.index) == NUM_OUT - 1) ||
      (res.kind == KIND_DELTA && 32'(res.index) == NUM_IN - 1))
    else $error("last flag on wrong index");

  // a forward or train item keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.ready && (op.cmd == CMD_FORWARD || op.cmd == CMD_TRAIN)
      |=> !op.ready)
    else $error("sequencer did not start");

  // counters stay inside the stores
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> 32'(i) < NUM_OUT && 32'(j) < NUM_IN)
    else $error("loop counter out of range");

  // weight updates only during the update sweep or a weight write
  a_wwrite: assert property (@(posedge clk) disable iff (rst)
    w_we |-> state == S_U_WB || (state == S_IDLE && accept))
    else $error("stray weight write");

endmodule

`default_nettype wire

// File: tb/sv/dsl_checker.sv
`timescale 1ns / 1ps

module dsl_checker
  import dsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dsl_op_if           op,
  dsl_res_if          res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic               kind;
    logic [5:0]         index;
    logic signed [15:0] val;
    logic               last;
  } layer_result_t;

  localparam int N_IN  = 16;
  localparam int N_OUT = 16;
  localparam int DEPTH = 256;

  logic signed [15:0] wt [N_OUT][N_IN];
  logic signed [15:0] act_in [N_IN];
  logic signed [15:0] act_out [N_OUT];
  logic signed [15:0] err_out [N_OUT];
  logic [15:0]        rate;
  logic [15:0]        sig_lut [DEPTH];
  layer_result_t      expected_results [$];

  function automatic longint floor_shift(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // exp(-x) with x in Q12, Q30 out: taylor series then ten squarings
  function automatic longint unsigned exp_q30(input longint unsigned x);
    longint unsigned u, u2, u3, u4, p;
    u  = x << 8;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    p  = (64'd1 << 30) - u + u2 / 2 - u3 / 6 + u4 / 24;
    for (int k = 0; k < 10; k++) p = (p * p + (64'd1 << 29)) >> 30;
    return p;
  endfunction

  function automatic logic signed [15:0] slope_delta(input longint e, input longint y);
    return clip16(floor_shift(e * y * (4096 - y), 24));
  endfunction

  initial begin
    longint v;
    longint unsigned den, r;
    for (int k = 0; k < DEPTH; k++) begin
      v   = -65536 + (longint'(2 * k + 1) * 65536) / DEPTH;
      den = (64'd1 << 30) + exp_q30((v < 0) ? -v : v);
      r   = ((64'd1 << 42) + (den >> 1)) / den;
      sig_lut[k] = (v < 0) ? 16'(4096 - longint'(r)) : 16'(r);
    end
    fail_count = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic forward_pass();
    longint acc, q;
    for (int i = 0; i < N_OUT; i++) begin
      acc = 0;
      for (int j = 0; j < N_IN; j++) acc += longint'(act_in[j]) * longint'(wt[i][j]);
      q = clip16(floor_shift(acc, 12));
      act_out[i] = sig_lut[((q + 32768) * DEPTH) >> 16];
      expected_results.push_back('{KIND_ACT, 6'(i), act_out[i], i == N_OUT - 1});
    end
  endtask

  task automatic train_pass();
    longint dw, acc;
    for (int i = 0; i < N_OUT; i++)
      for (int j = 0; j < N_IN; j++) begin
        dw = floor_shift(longint'(act_in[j]) * longint'(err_out[i]) * longint'({1'b0, rate}), 28);
        wt[i][j] = clip16(longint'(wt[i][j]) - dw);
      end
    // back-propagated error uses the updated weights
    for (int j = 0; j < N_IN; j++) begin
      acc = 0;
      for (int i = 0; i < N_OUT; i++) acc += longint'(wt[i][j]) * longint'(err_out[i]);
      expected_results.push_back('{KIND_DELTA, 6'(j),
          slope_delta(clip16(floor_shift(acc, 12)), act_in[j]), j == N_IN - 1});
    end
  endtask

  always @(posedge clk) begin
    layer_result_t want;
    if (rst) begin
      rate = RATE_RESET;
      for (int i = 0; i < N_OUT; i++) begin
        act_out[i] = '0;
        err_out[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_RATE))
        rate = pwdata[15:0];
      if (op.valid && op.ready) begin
        case (cmd_t'(op.cmd))
          CMD_WEIGHT:  if (op.row < N_OUT && op.col < N_IN) wt[op.row][op.col] = op.value;
          CMD_INPUT:   if (op.col < N_IN) act_in[op.col] = op.value;
          CMD_FORWARD: forward_pass();
          CMD_TARGET:
            if (op.row < N_OUT)
              err_out[op.row] = slope_delta(longint'(act_out[op.row]) - longint'(op.value),
                                            act_out[op.row]);
          CMD_DELTA:   if (op.row < N_OUT) err_out[op.row] = op.value;
          CMD_TRAIN:   train_pass();
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result index", res.index, -1);
        end else begin
          want = expected_results.pop_front();
          if (res.kind !== want.kind) report_mismatch("kind", res.kind, want.kind);
          if (res.index !== want.index) report_mismatch("index", res.index, want.index);
          if (res.result_value !== want.val)
            report_mismatch($sformatf("value of %0d", want.index), res.result_value, want.val);
          if (res.last !== want.last) report_mismatch("last", res.last, want.last);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dsl_pkg::*;

  localparam longint CYCLE_LIMIT = 10_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  longint      cycles = 0;

  dsl_op_if  op ();
  dsl_res_if res ();

  dense_sigmoid_layer_trainer dut (
    .clk, .rst, .op, .res, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dsl_checker checker_i (
    .clk, .rst, .op, .res, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .outstanding
  );

  always #2 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random backpressure at the current rate
  initial res.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // one item on the op channel; valid stays high between back-to-back items
  task automatic send_item(input cmd_t cmd, input int row, input int col, input int val);
    while ($urandom_range(99) < tx_idle_pct) begin
      op.valid <= 1'b0;
      @(posedge clk);
    end
    op.valid <= 1'b1;
    op.cmd   <= cmd;
    op.row   <= 6'(row);
    op.col   <= 6'(col);
    op.value <= 16'(val);
    do @(posedge clk); while (!op.ready);
  endtask

  // drain every expected result, then let a trailing write finish
  task automatic wait_quiet();
    op.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // apb write with setup and access phases, only while the layer is quiet
  task automatic write_rate(input logic [15:0] rate_val);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_RATE);
    pwdata  <= {16'd0, rate_val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mix of full range, small q4.12 values, extremes and sigmoid-range targets
  function automatic int pick_value();
    case ($urandom_range(3))
      0: return int'($urandom_range(65535));
      1: return int'($urandom_range(8192)) - 4096;
      2: return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom_range(4096));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 33)
      send_item(CMD_WEIGHT, $urandom_range(15), $urandom_range(15), pick_value());
    else if (pick < 50)
      send_item(CMD_INPUT, $urandom_range(63), $urandom_range(15), pick_value());
    else if (pick < 58)
      send_item(CMD_FORWARD, $urandom_range(63), $urandom_range(63), pick_value());
    else if (pick < 72)
      send_item(CMD_TARGET, $urandom_range(15), $urandom_range(63), pick_value());
    else if (pick < 82)
      send_item(CMD_DELTA, $urandom_range(15), $urandom_range(63), pick_value());
    else if (pick < 90)
      send_item(CMD_TRAIN, $urandom_range(63), $urandom_range(63), pick_value());
    else if (pick < 95)
      // out-of-range index: ignored by the layer
      send_item(cmd_t'($urandom_range(1) ? 0 : 1), $urandom_range(16, 63),
                $urandom_range(16, 63), pick_value());
    else
      // undefined command codes
      send_item(cmd_t'($urandom_range(6, 7)), $urandom_range(63), $urandom_range(63),
                pick_value());
  endtask

  initial begin
    op.valid = 1'b0;
    op.cmd   = CMD_WEIGHT;
    op.row   = '0;
    op.col   = '0;
    op.value = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every weight and input gets written before any pass reads them
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++) send_item(CMD_WEIGHT, i, j, pick_value());
    for (int j = 0; j < 16; j++) send_item(CMD_INPUT, 0, j, pick_value());

    // directed: extremes, every command, ignored indexes and codes
    send_item(CMD_WEIGHT, 0, 0, 32767);
    send_item(CMD_WEIGHT, 15, 15, -32768);
    send_item(CMD_INPUT, 0, 0, 32767);
    send_item(CMD_INPUT, 0, 15, -32768);
    send_item(CMD_FORWARD, 0, 0, 0);
    send_item(CMD_TARGET, 0, 0, 32767);
    send_item(CMD_TARGET, 15, 0, -32768);
    send_item(CMD_TARGET, 7, 0, 4096);
    send_item(CMD_DELTA, 1, 0, -32768);
    send_item(CMD_DELTA, 14, 0, 32767);
    send_item(CMD_TRAIN, 0, 0, 0);
    send_item(CMD_WEIGHT, 16, 0, 1234);
    send_item(CMD_WEIGHT, 0, 63, 1234);
    send_item(CMD_INPUT, 0, 63, -1);
    send_item(CMD_TARGET, 63, 0, 100);
    send_item(CMD_DELTA, 40, 0, 100);
    send_item(cmd_t'(6), 63, 63, -1);
    send_item(cmd_t'(7), 42, 21, 21845);
    send_item(CMD_FORWARD, 63, 63, -1);

    // hold the sender until the layer has caught up
    wait_quiet();
    send_item(CMD_TRAIN, 0, 0, 0);

    write_rate(16'd0);
    send_item(CMD_TRAIN, 0, 0, 0);
    write_rate(16'hffff);
    send_item(CMD_DELTA, 3, 0, 32767);
    send_item(CMD_TRAIN, 0, 0, 0);

    // random phase: receiver slow, then sender slow, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 77 : 0;
      rx_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 19 : 0;
      case (phase)
        0: write_rate(RATE_RESET);
        1: write_rate(16'($urandom_range(65535)));
        default: write_rate(16'($urandom_range(256)));
      endcase
      for (int n = 0; n < 55; n++) random_item();
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
sv/dsl_pkg.sv
sv/dsl_op_if.sv
sv/dsl_res_if.sv
sv/dense_sigmoid_layer_trainer.sv
tb/sv/dsl_checker.sv
tb/sv/tb_top.sv
